>>> rtl/core/lvlfd_pkg.sv
// Package for the four-channel LED level fader.
// Holds the item codes, register indexes, widths and the per-channel
// slew and clamp functions. No dependencies.
`default_nettype none

package lvlfd_pkg;

  localparam int unsigned NumChannels = 4;
  localparam int unsigned NumPresets  = 5;
  localparam int unsigned LevelW      = 7;
  localparam int unsigned TargetW     = 8;
  localparam int unsigned PresetW     = 32;
  localparam int unsigned CfgIdxW     = 3;
  localparam int unsigned OpW         = 2;
  localparam int unsigned PresetIdxW  = 3;

  // Input beat payload: preset_index then manual_0..manual_3, padded to bytes.
  localparam int unsigned InDataW  = 40;
  // Output beat payload: level_0..level_3 then moving, padded to bytes.
  localparam int unsigned OutDataW = 32;

  localparam logic [LevelW-1:0] LevelMax = 7'd100;

  typedef enum logic [OpW-1:0] {
    OP_TICK   = 2'd0,
    OP_PRESET = 2'd1,
    OP_MANUAL = 2'd2
  } op_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_PRESET_OFF    = 3'd0,
    CFG_PRESET_LOW    = 3'd1,
    CFG_PRESET_MEDIUM = 3'd2,
    CFG_PRESET_HIGH   = 3'd3,
    CFG_PRESET_BEAM   = 3'd4
  } cfg_idx_e;

  localparam logic [PresetW-1:0] PresetOffRst    = 32'h0000_0000;
  localparam logic [PresetW-1:0] PresetLowRst    = 32'h0000_0200;
  localparam logic [PresetW-1:0] PresetMediumRst = 32'h040A_0A04;
  localparam logic [PresetW-1:0] PresetHighRst   = 32'h0C26_260C;
  localparam logic [PresetW-1:0] PresetBeamRst   = 32'h3C00_003C;

  typedef logic [LevelW-1:0] level_t;

  function automatic level_t clamp_level(logic [TargetW-1:0] v);
    level_t r;
    if (v > TargetW'(LevelMax)) begin
      r = LevelMax;
    end else begin
      r = v[LevelW-1:0];
    end
    return r;
  endfunction

  // One step toward the target. The step sizes never exceed the distance
  // in their band, so no overshoot check is needed beyond the equal case.
  function automatic level_t slew_one(level_t cur, level_t tgt);
    level_t gap;
    level_t step;
    level_t r;
    gap = (cur > tgt) ? (cur - tgt) : (tgt - cur);
    if (gap < 7'd10) begin
      step = 7'd1;
    end else if (gap < 7'd30) begin
      step = 7'd5;
    end else begin
      step = 7'd10;
    end
    if (cur == tgt) begin
      r = cur;
    end else if (cur > tgt) begin
      r = cur - step;
    end else begin
      r = cur + step;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/four_channel_led_level_fader_unit.sv
// Four-channel LED level fader, top level.
// Uses lvlfd_pkg for codes, widths and the slew and clamp functions.
//
// Usage:
//   Input beats arrive on the s_axis channel. tuser carries the item kind
//   (tick, apply preset, apply manual targets); tdata carries the preset
//   number and four manual targets. Each input beat yields exactly one
//   output beat on m_axis with the four current duty levels and a flag that
//   is set while any channel still differs from its target.
//   A tick moves every channel toward its target by 1, 5 or 10 depending on
//   the remaining distance. Apply items change only the targets.
//   The five preset registers are written through the cfg port, one 32-bit
//   register per write; the user must write them only while no beat is in flight, the block does not enforce it.
// Timing:
//   Results are registered: a beat accepted at a clock edge is shown on
//   m_axis in the cycle after. Throughput is one beat per cycle while the
//   receiver holds m_axis_tready high; state and result update in one pass.
// Reset and stalls:
//   Reset sets all current levels to 1, all targets to 0, the presets to
//   their default values and empties the output register. While the
//   receiver holds m_axis_tready low with a result waiting, s_axis_tready
//   drops and the result holds; a new beat is taken in the cycle the
//   waiting result leaves.
`default_nettype none

module four_channel_led_level_fader_unit (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // Configuration write port.
  input  wire logic                            cfg_we_i,
  input  wire logic [lvlfd_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [lvlfd_pkg::PresetW-1:0]   cfg_wdata_i,
  // Input stream.
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  // tdata from bit 0 up: preset_index[2:0], manual_0..manual_3 (8 bits each).
  input  wire logic [lvlfd_pkg::InDataW-1:0]   s_axis_tdata,
  // tuser from bit 0 up: op[1:0].
  input  wire logic [lvlfd_pkg::OpW-1:0]       s_axis_tuser,
  // Output stream.
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  // tdata from bit 0 up: level_0..level_3 (7 bits each), moving.
  output logic [lvlfd_pkg::OutDataW-1:0]       m_axis_tdata
);

  import lvlfd_pkg::*;

  logic [PresetW-1:0] preset_q [NumPresets];
  level_t             target_q [NumChannels];
  level_t             target_d [NumChannels];
  level_t             cur_q    [NumChannels];
  level_t             cur_d    [NumChannels];

  logic                    out_valid_q;
  logic [OutDataW-1:0]     out_data_q;
  logic [OutDataW-1:0]     out_data_d;

  logic                    in_beat;
  logic                    moving;
  logic [PresetIdxW-1:0]   preset_idx;
  logic [PresetW-1:0]      preset_word;
  logic                    preset_ok;
  logic [TargetW-1:0]      manual [NumChannels];

  // The output register frees up in the same cycle its beat is taken.
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_beat       = s_axis_tvalid && s_axis_tready;

  assign preset_idx = s_axis_tdata[PresetIdxW-1:0];
  assign preset_ok  = (preset_idx < PresetIdxW'(NumPresets));
  assign preset_word = preset_ok ? preset_q[preset_idx] : '0;

  always_comb begin
    for (int c = 0; c < NumChannels; c++) begin
      manual[c] = s_axis_tdata[PresetIdxW + TargetW*c +: TargetW];
    end
  end

  // Next channel state for the beat on the input side.
  always_comb begin
    for (int c = 0; c < NumChannels; c++) begin
      target_d[c] = target_q[c];
      cur_d[c]    = cur_q[c];
    end
    case (s_axis_tuser)
      OP_TICK: begin
        for (int c = 0; c < NumChannels; c++) begin
          cur_d[c] = slew_one(cur_q[c], target_q[c]);
        end
      end
      OP_PRESET: begin
        for (int c = 0; c < NumChannels; c++) begin
          target_d[c] = clamp_level(preset_word[TargetW*c +: TargetW]);
        end
      end
      OP_MANUAL: begin
        for (int c = 0; c < NumChannels; c++) begin
          target_d[c] = clamp_level(manual[c]);
        end
      end
      default: begin
        // Unused kind: state holds, the result still reports it.
      end
    endcase
  end

  always_comb begin
    moving     = 1'b0;
    out_data_d = '0;
    for (int c = 0; c < NumChannels; c++) begin
      out_data_d[LevelW*c +: LevelW] = cur_d[c];
      if (cur_d[c] != target_d[c]) begin
        moving = 1'b1;
      end
    end
    out_data_d[LevelW*NumChannels] = moving;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      preset_q[CFG_PRESET_OFF]    <= PresetOffRst;
      preset_q[CFG_PRESET_LOW]    <= PresetLowRst;
      preset_q[CFG_PRESET_MEDIUM] <= PresetMediumRst;
      preset_q[CFG_PRESET_HIGH]   <= PresetHighRst;
      preset_q[CFG_PRESET_BEAM]   <= PresetBeamRst;
    end else if (cfg_we_i && (cfg_idx_i < CfgIdxW'(NumPresets))) begin
      preset_q[cfg_idx_i] <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < NumChannels; c++) begin
        target_q[c] <= '0;
        cur_q[c]    <= LevelW'(1);
      end
    end else if (in_beat) begin
      for (int c = 0; c < NumChannels; c++) begin
        target_q[c] <= target_d[c];
        cur_q[c]    <= cur_d[c];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_beat) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_beat) begin
      out_data_q <= out_data_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

`default_nettype wire

>>> rtl/core/lvlfd_checker.sv
// Port-level checker for the four-channel LED level fader and its bind.
// Depends on lvlfd_pkg for widths; sees only the top level's ports.
`default_nettype none

module lvlfd_checker (
  input wire logic                            clk_i,
  input wire logic                            rst_ni,
  input wire logic                            cfg_we_i,
  input wire logic [lvlfd_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input wire logic [lvlfd_pkg::PresetW-1:0]   cfg_wdata_i,
  input wire logic                            s_axis_tvalid,
  input wire logic                            s_axis_tready,
  input wire logic [lvlfd_pkg::InDataW-1:0]   s_axis_tdata,
  input wire logic [lvlfd_pkg::OpW-1:0]       s_axis_tuser,
  input wire logic                            m_axis_tvalid,
  input wire logic                            m_axis_tready,
  input wire logic [lvlfd_pkg::OutDataW-1:0]  m_axis_tdata
);

  import lvlfd_pkg::*;

  logic s_beat;
  logic m_beat;

  assign s_beat = s_axis_tvalid && s_axis_tready;
  assign m_beat = m_axis_tvalid && m_axis_tready;

  // A stalled result stays put until it is taken.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("stalled output beat changed or dropped");

  // Every accepted input beat shows up as a result on the next cycle.
  a_in_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_beat |=> m_axis_tvalid)
    else $error("input beat did not produce an output beat");

  // No result appears without an input beat behind it.
  a_no_extra: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!s_beat && (m_beat || !m_axis_tvalid)) |=> !m_axis_tvalid)
    else $error("output beat without a matching input beat");

  // Reported levels never exceed full duty.
  a_level_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ((m_axis_tdata[6:0] <= LevelMax) &&
                       (m_axis_tdata[13:7] <= LevelMax) &&
                       (m_axis_tdata[20:14] <= LevelMax) &&
                       (m_axis_tdata[27:21] <= LevelMax)))
    else $error("reported level above full duty");

endmodule

bind four_channel_led_level_fader_unit lvlfd_checker u_lvlfd_checker (.*);

`default_nettype wire
